/* rtl/fvo_pkg.sv */
// ---------------------------------------------------------------------------
// fvo_pkg
// Shared types and constants of the frustum vertex outcode block: register
// map, register widths and reset values, and bit positions of the plane mask.
// ---------------------------------------------------------------------------
`default_nettype none

package fvo_pkg;

   // register widths
   localparam int FAR_W       = 32;
   localparam int TRIG_W      = 18;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int MASK_W      = 6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_NEG_FAR_DEPTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HORIZ_SIN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HORIZ_COS     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_VERT_SIN      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_VERT_COS      = 3'd4;

   // register reset values
   localparam logic signed [FAR_W-1:0]  NEG_FAR_DEPTH_RST = -32'sd65536000;
   localparam logic signed [TRIG_W-1:0] TRIG_RST          = 18'sd46341;

   // plane mask bit positions
   localparam int MASK_NEAR   = 0;
   localparam int MASK_FAR    = 1;
   localparam int MASK_LEFT   = 2;
   localparam int MASK_RIGHT  = 3;
   localparam int MASK_TOP    = 4;
   localparam int MASK_BOTTOM = 5;

   // frustum set-up as held in the register file
   typedef struct packed {
      logic signed [FAR_W-1:0]  neg_far_depth;
      logic signed [TRIG_W-1:0] horiz_sin;
      logic signed [TRIG_W-1:0] horiz_cos;
      logic signed [TRIG_W-1:0] vert_sin;
      logic signed [TRIG_W-1:0] vert_cos;
   } cfg_type;

   // near and far outcome passed from the product stage to the compare stage
   typedef struct packed {
      logic near;
      logic far;
   } depth_type;

endpackage

`default_nettype wire

/* rtl/fvo_req_if.sv */
// ---------------------------------------------------------------------------
// fvo_req_if
// Vertex request channel: command, position and error vector, valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface fvo_req_if #(
   parameter int COORD_BITS = 32
);
   logic                         valid;
   logic                         ready;
   logic                         cmd;
   logic signed [COORD_BITS-1:0] pos_x;
   logic signed [COORD_BITS-1:0] pos_y;
   logic signed [COORD_BITS-1:0] pos_z;
   logic signed [COORD_BITS-1:0] err_x;
   logic signed [COORD_BITS-1:0] err_y;
   logic signed [COORD_BITS-1:0] err_z;

   modport source (
      output valid, cmd, pos_x, pos_y, pos_z, err_x, err_y, err_z,
      input  ready
   );

   modport sink (
      input  valid, cmd, pos_x, pos_y, pos_z, err_x, err_y, err_z,
      output ready
   );
endinterface

`default_nettype wire

/* rtl/fvo_rsp_if.sv */
// ---------------------------------------------------------------------------
// fvo_rsp_if
// Outcode result channel: six-bit plane mask, valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface fvo_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] plane_mask;

   modport source (
      output valid, plane_mask,
      input  ready
   );

   modport sink (
      input  valid, plane_mask,
      output ready
   );
endinterface

`default_nettype wire

/* rtl/fvo_csr.sv */
// ---------------------------------------------------------------------------
// fvo_csr
// Register file holding the far distance and the plane sines and cosines.
// ---------------------------------------------------------------------------
`default_nettype none

module fvo_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [fvo_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fvo_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output fvo_pkg::cfg_type                   cfg
);
   import fvo_pkg::*;

   cfg_type cfg_ff;

   // register writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.neg_far_depth <= NEG_FAR_DEPTH_RST;
         cfg_ff.horiz_sin     <= TRIG_RST;
         cfg_ff.horiz_cos     <= TRIG_RST;
         cfg_ff.vert_sin      <= TRIG_RST;
         cfg_ff.vert_cos      <= TRIG_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_NEG_FAR_DEPTH: cfg_ff.neg_far_depth <= csr_wdata[FAR_W-1:0];
            REG_HORIZ_SIN:     cfg_ff.horiz_sin     <= csr_wdata[TRIG_W-1:0];
            REG_HORIZ_COS:     cfg_ff.horiz_cos     <= csr_wdata[TRIG_W-1:0];
            REG_VERT_SIN:      cfg_ff.vert_sin      <= csr_wdata[TRIG_W-1:0];
            REG_VERT_COS:      cfg_ff.vert_cos      <= csr_wdata[TRIG_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* rtl/fvo_sum_stage.sv */
// ---------------------------------------------------------------------------
// fvo_sum_stage
// Input stage: forms P+E and P-E (error forced to zero in point mode) with
// one guard bit and registers the two points.
// ---------------------------------------------------------------------------
`default_nettype none

module fvo_sum_stage #(
   parameter int COORD_BITS = 32,
   localparam int SUM_W     = COORD_BITS + 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic                         cmd,
   input  logic signed [COORD_BITS-1:0] pos_x,
   input  logic signed [COORD_BITS-1:0] pos_y,
   input  logic signed [COORD_BITS-1:0] pos_z,
   input  logic signed [COORD_BITS-1:0] err_x,
   input  logic signed [COORD_BITS-1:0] err_y,
   input  logic signed [COORD_BITS-1:0] err_z,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [SUM_W-1:0]      ax,
   output logic signed [SUM_W-1:0]      ay,
   output logic signed [SUM_W-1:0]      az,
   output logic signed [SUM_W-1:0]      bx,
   output logic signed [SUM_W-1:0]      by,
   output logic signed [SUM_W-1:0]      bz
);
   logic signed [COORD_BITS-1:0] ex, ey, ez;
   logic signed [SUM_W-1:0]      ax_in, ay_in, az_in, bx_in, by_in, bz_in;
   logic signed [SUM_W-1:0]      ax_ff, ay_ff, az_ff, bx_ff, by_ff, bz_ff;
   logic                         valid_ff;

   // error vector only counts in terrain mode
   assign ex = cmd ? err_x : '0;
   assign ey = cmd ? err_y : '0;
   assign ez = cmd ? err_z : '0;

   // exact sums and differences
   assign ax_in = SUM_W'(pos_x) + SUM_W'(ex);
   assign ay_in = SUM_W'(pos_y) + SUM_W'(ey);
   assign az_in = SUM_W'(pos_z) + SUM_W'(ez);
   assign bx_in = SUM_W'(pos_x) - SUM_W'(ex);
   assign by_in = SUM_W'(pos_y) - SUM_W'(ey);
   assign bz_in = SUM_W'(pos_z) - SUM_W'(ez);

   // stage advances when empty or when the next stage takes its item
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
         az_ff <= az_in;
         bx_ff <= bx_in;
         by_ff <= by_in;
         bz_ff <= bz_in;
      end
   end

   assign out_valid = valid_ff;
   assign ax = ax_ff;
   assign ay = ay_ff;
   assign az = az_ff;
   assign bx = bx_ff;
   assign by = by_ff;
   assign bz = bz_ff;

endmodule

`default_nettype wire

/* rtl/fvo_prod_stage.sv */
// ---------------------------------------------------------------------------
// fvo_prod_stage
// Product stage: full-width products of the plane sines and cosines with the
// two points, plus the near and far depth tests.
// ---------------------------------------------------------------------------
`default_nettype none

module fvo_prod_stage #(
   parameter int SUM_W        = 33,
   localparam int PROD_W      = fvo_pkg::TRIG_W + SUM_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  fvo_pkg::cfg_type         cfg,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic signed [SUM_W-1:0]  ax,
   input  logic signed [SUM_W-1:0]  ay,
   input  logic signed [SUM_W-1:0]  az,
   input  logic signed [SUM_W-1:0]  bx,
   input  logic signed [SUM_W-1:0]  by,
   input  logic signed [SUM_W-1:0]  bz,
   output logic                     out_valid,
   input  logic                     out_ready,
   output fvo_pkg::depth_type       depth,
   output logic signed [PROD_W-1:0] hsx_a,
   output logic signed [PROD_W-1:0] hcz_a,
   output logic signed [PROD_W-1:0] vsy_a,
   output logic signed [PROD_W-1:0] vcz_a,
   output logic signed [PROD_W-1:0] hsx_b,
   output logic signed [PROD_W-1:0] hcz_b,
   output logic signed [PROD_W-1:0] vsy_b,
   output logic signed [PROD_W-1:0] vcz_b
);
   import fvo_pkg::*;

   localparam int CMP_W = (SUM_W > FAR_W) ? SUM_W : FAR_W;

   logic                     valid_ff;
   depth_type                depth_in, depth_ff;
   logic                     a_front, b_front, a_beyond, b_beyond;
   logic signed [PROD_W-1:0] hsx_a_ff, hcz_a_ff, vsy_a_ff, vcz_a_ff;
   logic signed [PROD_W-1:0] hsx_b_ff, hcz_b_ff, vsy_b_ff, vcz_b_ff;

   // depth tests: far only counts when the near test fails
   assign a_front  = !az[SUM_W-1] && (az != '0);
   assign b_front  = !bz[SUM_W-1] && (bz != '0);
   assign a_beyond = CMP_W'(az) < CMP_W'(cfg.neg_far_depth);
   assign b_beyond = CMP_W'(bz) < CMP_W'(cfg.neg_far_depth);
   assign depth_in.near = a_front && b_front;
   assign depth_in.far  = !(a_front && b_front) && a_beyond && b_beyond;

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // products registered before the compare stage
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         depth_ff <= depth_in;
         hsx_a_ff <= PROD_W'(cfg.horiz_sin) * PROD_W'(ax);
         hcz_a_ff <= PROD_W'(cfg.horiz_cos) * PROD_W'(az);
         vsy_a_ff <= PROD_W'(cfg.vert_sin)  * PROD_W'(ay);
         vcz_a_ff <= PROD_W'(cfg.vert_cos)  * PROD_W'(az);
         hsx_b_ff <= PROD_W'(cfg.horiz_sin) * PROD_W'(bx);
         hcz_b_ff <= PROD_W'(cfg.horiz_cos) * PROD_W'(bz);
         vsy_b_ff <= PROD_W'(cfg.vert_sin)  * PROD_W'(by);
         vcz_b_ff <= PROD_W'(cfg.vert_cos)  * PROD_W'(bz);
      end
   end

   assign out_valid = valid_ff;
   assign depth     = depth_ff;
   assign hsx_a     = hsx_a_ff;
   assign hcz_a     = hcz_a_ff;
   assign vsy_a     = vsy_a_ff;
   assign vcz_a     = vcz_a_ff;
   assign hsx_b     = hsx_b_ff;
   assign hcz_b     = hcz_b_ff;
   assign vsy_b     = vsy_b_ff;
   assign vcz_b     = vcz_b_ff;

endmodule

`default_nettype wire

/* rtl/fvo_cmp_stage.sv */
// ---------------------------------------------------------------------------
// fvo_cmp_stage
// Compare stage and output register: side plane tests from the products and
// assembly of the plane mask.
// ---------------------------------------------------------------------------
`default_nettype none

module fvo_cmp_stage #(
   parameter int PROD_W       = 51,
   localparam int DIFF_W      = PROD_W + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  fvo_pkg::depth_type          depth,
   input  logic signed [PROD_W-1:0]    hsx_a,
   input  logic signed [PROD_W-1:0]    hcz_a,
   input  logic signed [PROD_W-1:0]    vsy_a,
   input  logic signed [PROD_W-1:0]    vcz_a,
   input  logic signed [PROD_W-1:0]    hsx_b,
   input  logic signed [PROD_W-1:0]    hcz_b,
   input  logic signed [PROD_W-1:0]    vsy_b,
   input  logic signed [PROD_W-1:0]    vcz_b,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [fvo_pkg::MASK_W-1:0]  plane_mask
);
   import fvo_pkg::*;

   logic signed [DIFF_W-1:0] left_a, left_b, right_a, right_b;
   logic signed [DIFF_W-1:0] top_a, top_b, bot_a, bot_b;
   logic [MASK_W-1:0]        mask_in, mask_ff;
   logic                     valid_ff;

   // s*x < c*z  is  s*x - c*z < 0; negated sine gives s*x + c*z > 0
   assign left_a  = DIFF_W'(hsx_a) - DIFF_W'(hcz_a);
   assign left_b  = DIFF_W'(hsx_b) - DIFF_W'(hcz_b);
   assign right_a = DIFF_W'(hsx_a) + DIFF_W'(hcz_a);
   assign right_b = DIFF_W'(hsx_b) + DIFF_W'(hcz_b);
   assign top_a   = DIFF_W'(vsy_a) - DIFF_W'(vcz_a);
   assign top_b   = DIFF_W'(vsy_b) - DIFF_W'(vcz_b);
   assign bot_a   = DIFF_W'(vsy_a) + DIFF_W'(vcz_a);
   assign bot_b   = DIFF_W'(vsy_b) + DIFF_W'(vcz_b);

   // mask assembly, both points must pass each plane
   always_comb begin
      mask_in              = '0;
      mask_in[MASK_NEAR]   = depth.near;
      mask_in[MASK_FAR]    = depth.far;
      mask_in[MASK_LEFT]   = left_a[DIFF_W-1] && left_b[DIFF_W-1];
      mask_in[MASK_RIGHT]  = !right_a[DIFF_W-1] && (right_a != '0) &&
                             !right_b[DIFF_W-1] && (right_b != '0);
      mask_in[MASK_TOP]    = top_a[DIFF_W-1] && top_b[DIFF_W-1];
      mask_in[MASK_BOTTOM] = !bot_a[DIFF_W-1] && (bot_a != '0) &&
                             !bot_b[DIFF_W-1] && (bot_b != '0);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         mask_ff <= mask_in;
      end
   end

   assign out_valid  = valid_ff;
   assign plane_mask = mask_ff;

endmodule

`default_nettype wire

/* rtl/frustum_vertex_outcode.sv */
// ---------------------------------------------------------------------------
// frustum_vertex_outcode
// Classifies an eye-space vertex (or a vertex with error vector in terrain
// mode) against a symmetric view frustum and returns a six-bit plane mask.
//
//   channel  dir  handshake           payload
//   req_ch   in   valid/ready         cmd, pos_x/y/z, err_x/y/z
//   rsp_ch   out  valid/ready         plane_mask
//   csr_*    in   csr_we (no stall)   csr_index, csr_wdata
//
// Three register stages: sums, products, compares. An item passes the sum,
// product and compare registers in that order before its result is offered;
// one item is taken every cycle unless the output stalls a full pipeline.
// The product stage (eight signed multiplies in parallel) sets the clock.
// Each stage moves on when empty or when its successor takes its item, so
// bubbles are squeezed out while the output is stalled.
// Reset is synchronous: it empties the pipeline and loads register defaults.
// ---------------------------------------------------------------------------
`default_nettype none

module frustum_vertex_outcode #(
   parameter int COORD_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   fvo_req_if.sink                         req_ch,
   fvo_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [fvo_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fvo_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fvo_pkg::*;

   localparam int SUM_W  = COORD_BITS + 1;
   localparam int PROD_W = TRIG_W + SUM_W;

   cfg_type                  cfg;
   depth_type                depth;
   logic                     s1_valid, s1_ready, s2_valid, s2_ready;
   logic signed [SUM_W-1:0]  ax, ay, az, bx, by, bz;
   logic signed [PROD_W-1:0] hsx_a, hcz_a, vsy_a, vcz_a;
   logic signed [PROD_W-1:0] hsx_b, hcz_b, vsy_b, vcz_b;

   // frustum set-up registers
   fvo_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // point pair forming
   fvo_sum_stage #(
      .COORD_BITS (COORD_BITS)
   ) u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .cmd       (req_ch.cmd),
      .pos_x     (req_ch.pos_x),
      .pos_y     (req_ch.pos_y),
      .pos_z     (req_ch.pos_z),
      .err_x     (req_ch.err_x),
      .err_y     (req_ch.err_y),
      .err_z     (req_ch.err_z),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .ax        (ax),
      .ay        (ay),
      .az        (az),
      .bx        (bx),
      .by        (by),
      .bz        (bz)
   );

   // plane products and depth tests
   fvo_prod_stage #(
      .SUM_W (SUM_W)
   ) u_prod (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .ax        (ax),
      .ay        (ay),
      .az        (az),
      .bx        (bx),
      .by        (by),
      .bz        (bz),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .depth     (depth),
      .hsx_a     (hsx_a),
      .hcz_a     (hcz_a),
      .vsy_a     (vsy_a),
      .vcz_a     (vcz_a),
      .hsx_b     (hsx_b),
      .hcz_b     (hcz_b),
      .vsy_b     (vsy_b),
      .vcz_b     (vcz_b)
   );

   // side plane compares and result register
   fvo_cmp_stage #(
      .PROD_W (PROD_W)
   ) u_cmp (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s2_valid),
      .in_ready   (s2_ready),
      .depth      (depth),
      .hsx_a      (hsx_a),
      .hcz_a      (hcz_a),
      .vsy_a      (vsy_a),
      .vcz_a      (vcz_a),
      .hsx_b      (hsx_b),
      .hcz_b      (hcz_b),
      .vsy_b      (vsy_b),
      .vcz_b      (vcz_b),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .plane_mask (rsp_ch.plane_mask)
   );

endmodule

`default_nettype wire

/* rtl/fvo_checker.sv */
// ---------------------------------------------------------------------------
// fvo_checker
// Port-level checks of the outcode block, attached to the top level by bind.
// ---------------------------------------------------------------------------
`default_nettype none

module fvo_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [fvo_pkg::MASK_W-1:0]  plane_mask
);
   import fvo_pkg::*;

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   // a stalled result keeps its mask
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(plane_mask))
      else $error("result item changed while stalled");

   // near and far are exclusive
   a_near_far: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(plane_mask[MASK_NEAR] && plane_mask[MASK_FAR]))
      else $error("near and far both set");

   // an offered item is only held off by a full, stalled pipeline
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled with room in the pipeline");

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind frustum_vertex_outcode fvo_checker u_fvo_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .plane_mask (rsp_ch.plane_mask)
);

`default_nettype wire
